// ----- rtl/dlr_pkg.sv -----
// Shared types for the DDA line rasterizer: controller command and
// datapath status bundles. No dependencies.
`timescale 1ns / 1ps

package dlr_pkg;

  typedef struct packed {
    logic start_load;  // accepted start request: load endpoints, emit first point
    logic prep;        // form |d| and k, seed the dividers
    logic div_step;    // one quotient bit per divider
    logic finish;      // load increments and step count
    logic step;        // accepted step request
  } dlr_cmd_t;

  typedef struct packed {
    logic zero_len;    // endpoints of the offered request coincide
    logic out_hold;    // result register full and not taken this cycle
  } dlr_status_t;

endpackage

// ----- rtl/dlr_in_if.sv -----
// Request channel of the line rasterizer: valid/ready plus command and endpoints.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface dlr_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

// ----- rtl/dlr_out_if.sv -----
// Point channel of the line rasterizer: valid/ready plus point and last flag.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface dlr_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic                         last_point;

  modport source (output valid, px, py, last_point, input ready);
  modport sink   (input valid, px, py, last_point, output ready);
endinterface

// ----- rtl/dda_line_rasterizer_core.sv -----
// DDA line rasterizer. A start request (func = 0) loads both endpoints and
// returns the first point at once; the per-step increments are then formed by
// two radix-2 dividers, one quotient bit per cycle, and the block takes no new
// request until they finish (a zero-length line skips the division and returns
// a single point marked last). Each step request (func = 1) returns the next
// point, rounded half up, so a line of k = max(|dx|,|dy|) returns k+1 points,
// the final one with last_point set; steps beyond the end return nothing. A
// request is taken while no division is running and the result register is
// empty or being read in the same cycle.
// Depends on dlr_pkg, dlr_in_if, dlr_out_if, dlr_ctrl and dlr_dpath.
`timescale 1ns / 1ps

module dda_line_rasterizer_core #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  dlr_in_if.sink    line_req,
  dlr_out_if.source point
);
  import dlr_pkg::*;

  dlr_cmd_t    cmd;
  dlr_status_t status;

  dlr_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (line_req.valid),
    .in_func  (line_req.func),
    .in_ready (line_req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dlr_dpath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .x_start    (line_req.x_start),
    .y_start    (line_req.y_start),
    .x_end      (line_req.x_end),
    .y_end      (line_req.y_end),
    .out_valid  (point.valid),
    .out_ready  (point.ready),
    .px         (point.px),
    .py         (point.py),
    .last_point (point.last_point)
  );

endmodule

// ----- rtl/dlr_div.sv -----
// Restoring radix-2 divider for the per-step increment: one quotient bit a cycle.
// Computes floor(num * 2^QW / den) for num <= den. No package dependency.
`timescale 1ns / 1ps

module dlr_div #(
  parameter int DW = 12,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          init,
  input  logic          step,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW:0]   quot
);

  logic [DW-1:0] den_q;
  logic [DW-1:0] rem;
  logic [DW:0]   rem2;
  logic          ge;
  logic [DW:0]   diff;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};
  assign diff = rem2 - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (init) begin
      den_q <= den;
      // integer bit is one only when num equals den; remainder then zero
      rem   <= (num == den) ? '0 : num;
      quot  <= {{QW{1'b0}}, num == den};
    end else if (step) begin
      rem  <= ge ? diff[DW-1:0] : rem2[DW-1:0];
      quot <= {quot[QW-1:0], ge};
    end
  end

endmodule

// ----- rtl/dlr_ctrl.sv -----
// Controller for the line rasterizer: sequences start, divide and step requests.
// Depends on dlr_pkg for the command and status bundles.
`timescale 1ns / 1ps

module dlr_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  input  dlr_pkg::dlr_status_t status,
  output dlr_pkg::dlr_cmd_t    cmd
);
  import dlr_pkg::*;

  localparam int CW = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

  typedef enum logic [1:0] {
    IDLE,
    PREP,
    DIV,
    FIN
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          accept;

  assign in_ready = (state == IDLE) && !status.out_hold;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.start_load = accept && !in_func;
    cmd.step       = accept && in_func;
    cmd.prep       = state == PREP;
    cmd.div_step   = state == DIV;
    cmd.finish     = state == FIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept && !in_func && !status.zero_len) state <= PREP;
        end
        PREP: begin
          state <= DIV;
          cnt   <= CW'(FRAC_BITS - 1);
        end
        DIV: begin
          if (cnt == '0) state <= FIN;
          else cnt <= cnt - 1'b1;
        end
        FIN: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/dlr_dpath.sv -----
// Datapath for the line rasterizer: endpoint deltas, two dividers, accumulators,
// step counter and the result register. Depends on dlr_pkg and dlr_div.
`timescale 1ns / 1ps

module dlr_dpath #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dlr_pkg::dlr_cmd_t            cmd,
  output dlr_pkg::dlr_status_t         status,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] px,
  output logic signed [COORD_BITS-1:0] py,
  output logic                         last_point
);
  import dlr_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int ACC = C + F;
  localparam int SW  = F + 2;

  logic signed [C:0]     dx, dy;
  logic [C-1:0]          adx, ady, kmax;
  logic [C-1:0]          k_q;
  logic [C-1:0]          steps_left;
  logic                  line_active;
  logic signed [ACC-1:0] x_acc, y_acc;
  logic signed [SW-1:0]  x_step, y_step;
  logic [F:0]            qx, qy;
  logic [SW-1:0]         qx_ext, qy_ext;
  logic                  emit;

  assign status.zero_len = (x_start == x_end) && (y_start == y_end);
  assign status.out_hold = out_valid && !out_ready;

  always_comb begin
    logic [C:0] nx, ny;
    nx   = -dx;
    ny   = -dy;
    adx  = dx[C] ? nx[C-1:0] : dx[C-1:0];
    ady  = dy[C] ? ny[C-1:0] : dy[C-1:0];
    kmax = (adx > ady) ? adx : ady;
  end

  dlr_div #(.DW(C), .QW(F)) u_div_x (
    .clk (clk), .init(cmd.prep), .step(cmd.div_step),
    .num (adx), .den (kmax), .quot(qx)
  );

  dlr_div #(.DW(C), .QW(F)) u_div_y (
    .clk (clk), .init(cmd.prep), .step(cmd.div_step),
    .num (ady), .den (kmax), .quot(qy)
  );

  assign qx_ext = {1'b0, qx};
  assign qy_ext = {1'b0, qy};

  assign emit = cmd.start_load || (cmd.step && line_active);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      steps_left  <= '0;
      out_valid   <= 1'b0;
      x_acc       <= '0;
      y_acc       <= '0;
      x_step      <= '0;
      y_step      <= '0;
      last_point  <= 1'b0;
    end else begin
      out_valid <= status.out_hold || emit;
      if (cmd.start_load) begin
        // abandon any line in progress; first point goes out now
        dx          <= {x_end[C-1], x_end} - {x_start[C-1], x_start};
        dy          <= {y_end[C-1], y_end} - {y_start[C-1], y_start};
        x_acc       <= {x_start, {F{1'b0}}};
        y_acc       <= {y_start, {F{1'b0}}};
        x_step      <= '0;
        y_step      <= '0;
        steps_left  <= '0;
        line_active <= 1'b0;
        last_point  <= status.zero_len;
      end else if (cmd.step) begin
        if (line_active) begin
          x_acc      <= x_acc + ACC'(x_step);
          y_acc      <= y_acc + ACC'(y_step);
          steps_left <= steps_left - 1'b1;
          last_point <= steps_left == C'(1);
          if (steps_left == C'(1)) line_active <= 1'b0;
        end
      end
      if (cmd.prep) k_q <= kmax;
      if (cmd.finish) begin
        x_step      <= dx[C] ? -qx_ext : qx_ext;
        y_step      <= dy[C] ? -qy_ext : qy_ext;
        steps_left  <= k_q;
        line_active <= 1'b1;
      end
    end
  end

  // round half up, then saturate to the coordinate range
  always_comb begin
    logic signed [ACC:0] xs, ys;
    logic [C:0]          xr, yr;
    xs = {x_acc[ACC-1], x_acc} + (ACC+1)'(1 << (F - 1));
    ys = {y_acc[ACC-1], y_acc} + (ACC+1)'(1 << (F - 1));
    xr = xs[ACC:F];
    yr = ys[ACC:F];
    if (xr[C] != xr[C-1]) px = xr[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    else px = xr[C-1:0];
    if (yr[C] != yr[C-1]) py = yr[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    else py = yr[C-1:0];
  end

endmodule
